### hdl/ivl_pkg.sv
// ----------------------------------------------------------------------------
// ivl_pkg: shared definitions for the inverse vector length block
// Default widths, fixed-point format constants and the control word that
// travels down the pipeline next to each beat.
// ----------------------------------------------------------------------------
`default_nettype none

package ivl_pkg;

  localparam int IVL_IN_WIDTH     = 16;
  localparam int IVL_OUT_WIDTH    = 24;
  localparam int IVL_IN_INT_BITS  = 4;
  localparam int IVL_OUT_INT_BITS = 8;

  typedef struct packed {
    logic valid;
    logic zero;
    logic sat;
  } ivl_ctrl_t;

endpackage

`default_nettype wire

### hdl/inverse_vector_length.sv
// ----------------------------------------------------------------------------
// inverse_vector_length: reciprocal Euclidean length of a 3-component row
// Returns floor(2^(IN_FRAC+OUT_FRAC) / sqrt(x*x + y*y + z*z)) as unsigned
// fixed point, saturated at the largest code, with a flag for a zero row.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, comp_x/y/z_i      | input
//   out     | out_valid_o, out_ready_i, inv_length_o,   | output
//           | zero_length_o, saturated_o                |
//
// A beat is accepted every cycle while the output is not stalled.
// One stage squares the components, one sums them and finds the special
// cases, and one stage per result bit runs the square root search.
// Reset clears only the control words (valid, zero and sat bits) of the pipeline.
// A stall at the output holds the whole pipeline in place.
// ----------------------------------------------------------------------------
`default_nettype none

module inverse_vector_length #(
  parameter int IN_WIDTH  = ivl_pkg::IVL_IN_WIDTH,
  parameter int OUT_WIDTH = ivl_pkg::IVL_OUT_WIDTH
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  signed [IN_WIDTH-1:0] comp_x_i,
  input  wire  signed [IN_WIDTH-1:0] comp_y_i,
  input  wire  signed [IN_WIDTH-1:0] comp_z_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [OUT_WIDTH-1:0]       inv_length_o,
  output logic                       zero_length_o,
  output logic                       saturated_o
);

  import ivl_pkg::*;

  localparam int SW     = 2*IN_WIDTH + 2;
  localparam int TS     = 2*(IN_WIDTH - IVL_IN_INT_BITS + OUT_WIDTH - IVL_OUT_INT_BITS);
  localparam int PW     = TS + 1;
  localparam int SAT_SH = TS - 2*OUT_WIDTH;
  localparam logic          SAT_OK  = (SAT_SH >= 0);
  localparam logic [SW-1:0] SAT_LIM = SW'(1) << (SAT_OK ? SAT_SH : 0);
  localparam logic [OUT_WIDTH-1:0] MAX_CODE = '1;

  logic en;

  logic [IN_WIDTH-1:0]   mag_x, mag_y, mag_z;
  logic                  va_q;
  logic [2*IN_WIDTH-1:0] sq_x_q, sq_y_q, sq_z_q;

  logic [SW-1:0]         sum_s;
  ivl_ctrl_t             ctrl_b_d, ctrl_b_q;
  logic [SW-1:0]         s_b_q;

  ivl_ctrl_t             ctrl_w [OUT_WIDTH+1];
  logic [SW-1:0]         s_w    [OUT_WIDTH+1];
  logic [PW-1:0]         p_w    [OUT_WIDTH+1];
  logic [PW-1:0]         r_w    [OUT_WIDTH+1];
  logic [OUT_WIDTH-1:0]  q_w    [OUT_WIDTH+1];

  assign en         = !ctrl_w[OUT_WIDTH].valid || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    mag_x = comp_x_i[IN_WIDTH-1] ? (~comp_x_i + IN_WIDTH'(1)) : comp_x_i;
    mag_y = comp_y_i[IN_WIDTH-1] ? (~comp_y_i + IN_WIDTH'(1)) : comp_y_i;
    mag_z = comp_z_i[IN_WIDTH-1] ? (~comp_z_i + IN_WIDTH'(1)) : comp_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      ctrl_b_q <= '0;
    end else if (en) begin
      va_q     <= in_valid_i;
      ctrl_b_q <= ctrl_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_x_q <= mag_x * mag_x;
      sq_y_q <= mag_y * mag_y;
      sq_z_q <= mag_z * mag_z;
      s_b_q  <= sum_s;
    end
  end

  always_comb begin
    sum_s          = SW'(sq_x_q) + SW'(sq_y_q) + SW'(sq_z_q);
    ctrl_b_d.valid = va_q;
    ctrl_b_d.zero  = (sum_s == '0);
    ctrl_b_d.sat   = (sum_s == '0) || (SAT_OK && (sum_s <= SAT_LIM));
  end

  assign ctrl_w[0] = ctrl_b_q;
  assign s_w[0]    = s_b_q;
  assign p_w[0]    = '0;
  assign r_w[0]    = '0;
  assign q_w[0]    = '0;

  for (genvar k = 0; k < OUT_WIDTH; k++) begin : g_bit
    ivl_bit_stage #(
      .IN_WIDTH  (IN_WIDTH),
      .OUT_WIDTH (OUT_WIDTH),
      .BIT       (OUT_WIDTH - 1 - k)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_w[k]),
      .s_i    (s_w[k]),
      .p_i    (p_w[k]),
      .r_i    (r_w[k]),
      .q_i    (q_w[k]),
      .ctrl_o (ctrl_w[k+1]),
      .s_o    (s_w[k+1]),
      .p_o    (p_w[k+1]),
      .r_o    (r_w[k+1]),
      .q_o    (q_w[k+1])
    );
  end

  assign out_valid_o   = ctrl_w[OUT_WIDTH].valid;
  assign zero_length_o = ctrl_w[OUT_WIDTH].zero;
  assign saturated_o   = ctrl_w[OUT_WIDTH].sat;
  assign inv_length_o  = ctrl_w[OUT_WIDTH].sat ? MAX_CODE : q_w[OUT_WIDTH];

  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |-> saturated_o)
    else $error("zero-length result without saturation");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> inv_length_o == MAX_CODE)
    else $error("saturated result not at the largest code");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> va_q)
    else $error("accepted beat did not enter the square stage");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ctrl_b_q) && $stable(va_q))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

### hdl/ivl_bit_stage.sv
// ----------------------------------------------------------------------------
// ivl_bit_stage: one result bit of the reciprocal square root search
// Tries to set bit BIT of the partial quotient q and keeps it when
// q*q*S stays at or below the scaled one. The running values P = q*q*S and
// R = q*S are updated with shifts and adds only.
// ----------------------------------------------------------------------------
`default_nettype none

module ivl_bit_stage #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 24,
  parameter int BIT       = 0
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire  ivl_pkg::ivl_ctrl_t  ctrl_i,
  input  wire  [2*IN_WIDTH+1:0]     s_i,
  input  wire  [2*(IN_WIDTH+OUT_WIDTH-ivl_pkg::IVL_IN_INT_BITS
                   -ivl_pkg::IVL_OUT_INT_BITS):0] p_i,
  input  wire  [2*(IN_WIDTH+OUT_WIDTH-ivl_pkg::IVL_IN_INT_BITS
                   -ivl_pkg::IVL_OUT_INT_BITS):0] r_i,
  input  wire  [OUT_WIDTH-1:0]      q_i,
  output ivl_pkg::ivl_ctrl_t        ctrl_o,
  output logic [2*IN_WIDTH+1:0]     s_o,
  output logic [2*(IN_WIDTH+OUT_WIDTH-ivl_pkg::IVL_IN_INT_BITS
                   -ivl_pkg::IVL_OUT_INT_BITS):0] p_o,
  output logic [2*(IN_WIDTH+OUT_WIDTH-ivl_pkg::IVL_IN_INT_BITS
                   -ivl_pkg::IVL_OUT_INT_BITS):0] r_o,
  output logic [OUT_WIDTH-1:0]      q_o
);

  import ivl_pkg::*;

  localparam int SW = 2*IN_WIDTH + 2;
  localparam int TS = 2*(IN_WIDTH - IVL_IN_INT_BITS + OUT_WIDTH - IVL_OUT_INT_BITS);
  localparam int PW = TS + 1;
  localparam int EW = PW + SW + 2*OUT_WIDTH + 2;
  localparam logic [PW+1:0] LIMIT = (PW+2)'(1) << TS;

  ivl_ctrl_t         ctrl_q;
  logic [SW-1:0]     s_q;
  logic [PW-1:0]     p_q, p_d;
  logic [PW-1:0]     r_q, r_d;
  logic [OUT_WIDTH-1:0] q_q, q_d;

  logic [OUT_WIDTH-1:0] cand;
  logic [EW-1:0]     term_r, term_s, term_add;
  logic              ovf;
  logic [PW+1:0]     trial;
  logic              fit;

  always_comb begin
    cand     = q_i | (OUT_WIDTH'(1) << BIT);
    term_r   = EW'(r_i) << (BIT + 1);
    term_s   = EW'(s_i) << (2*BIT);
    term_add = EW'(s_i) << BIT;
    ovf      = (|term_r[EW-1:PW]) | (|term_s[EW-1:PW]);
    trial    = (PW+2)'(p_i) + (PW+2)'(term_r[PW-1:0]) + (PW+2)'(term_s[PW-1:0]);
    fit      = !ovf && (trial <= LIMIT);
    p_d      = fit ? trial[PW-1:0] : p_i;
    r_d      = fit ? (r_i + term_add[PW-1:0]) : r_i;
    q_d      = fit ? cand : q_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_i;
      p_q <= p_d;
      r_q <= r_d;
      q_q <= q_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign s_o    = s_q;
  assign p_o    = p_q;
  assign r_o    = r_q;
  assign q_o    = q_q;

endmodule

`default_nettype wire
